/* rtl/brl_pkg.sv */
// Package with the shared constants and codes of the box region lookup.
`default_nettype none
package brl_pkg;

  localparam int unsigned MaxEntries = 64;
  localparam int unsigned MaxDims    = 4;
  localparam int unsigned EntryW     = $clog2(MaxEntries);
  localparam int unsigned DimW       = $clog2(MaxDims);
  localparam int unsigned CountW     = 7;
  localparam int unsigned DimCountW  = 3;
  localparam int unsigned AddrW      = EntryW + DimW;
  localparam int unsigned Depth      = MaxEntries * MaxDims;
  localparam int unsigned CoordW     = 32;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;

  localparam logic ActWrite  = 1'b0;
  localparam logic ActLookup = 1'b1;

  localparam logic [ApbAddrW-1:0] RegEntryCount = 3'd0;
  localparam logic [ApbAddrW-1:0] RegDimCount   = 3'd4;

endpackage
`default_nettype wire

/* rtl/box_region_lookup_with_hint.sv */
// Top level of the box region lookup with a last-hit hint.
//
// Channel   Direction  Handshake             Payload
// in        input      in_valid_i/in_stall_o  action, entry_sel, dim_sel, ranges, coords
// out       output     out_valid_o/out_stall_i found, hit_entry, from_hint
// config    input      APB write/read         entry_count, dim_count
//
// A range write passes through the push state. A lookup reads one bound pair per cycle from
// the bound memory: the hint check covers up to dim_count dimensions, and the scan
// up to entry_count * dim_count bound pairs, both counts saturated, while a lookup
// with zero dimensions makes one compare step; each then ends in the push state.
// Reset clears the counts, the hint and the handshake state; the bound memory
// is not cleared. A stalled result waits in the output register while the
// next item is taken and worked on.
`default_nettype none
module box_region_lookup_with_hint import brl_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic                action_i,
  input  wire logic [EntryW-1:0]   entry_sel_i,
  input  wire logic [DimW-1:0]     dim_sel_i,
  input  wire logic [CoordW-1:0]   range_low_i,
  input  wire logic [CoordW-1:0]   range_high_i,
  input  wire logic [CoordW-1:0]   coord_a_i,
  input  wire logic [CoordW-1:0]   coord_b_i,
  input  wire logic [CoordW-1:0]   coord_c_i,
  input  wire logic [CoordW-1:0]   coord_d_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic                found_o,
  output      logic [EntryW-1:0]   hit_entry_o,
  output      logic                from_hint_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output      logic [ApbDataW-1:0] prdata,
  output      logic                pready
);

  typedef enum logic [2:0] {
    StIdle,
    StScalar,
    StHint,
    StScan,
    StPush
  } state_e;

  state_e state_q, state_d;

  logic [CountW-1:0]    entry_count_q;
  logic [DimCountW-1:0] dim_count_q;
  logic [CountW-1:0]    n_eff;
  logic [DimCountW-1:0] dims_eff;

  logic [EntryW-1:0] hint_entry_q, hint_entry_d;
  logic              hint_valid_q, hint_valid_d;

  logic [EntryW-1:0] ent_q, ent_d;
  logic [DimW-1:0]   dim_q, dim_d;
  logic [CoordW-1:0] coord_q [MaxDims];

  logic              res_found_q, res_found_d;
  logic [EntryW-1:0] res_entry_q, res_entry_d;
  logic              res_hint_q, res_hint_d;

  logic              out_valid_q;
  logic              out_found_q;
  logic [EntryW-1:0] out_entry_q;
  logic              out_hint_q;

  logic [2*CoordW-1:0] mem [Depth];
  logic [2*CoordW-1:0] rdata_q;
  logic [AddrW-1:0]    rd_addr;
  logic                wr_en;

  logic              in_acc;
  logic              cfg_wr;
  logic [CoordW-1:0] lo_word, hi_word, pt;
  logic              inside_box;
  logic              last_dim;
  logic              last_ent;
  logic              out_free;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr)
      RegEntryCount: prdata = ApbDataW'(entry_count_q);
      RegDimCount:   prdata = ApbDataW'(dim_count_q);
      default:       prdata = '0;
    endcase
  end

  assign n_eff    = (entry_count_q > CountW'(MaxEntries)) ? CountW'(MaxEntries)
                                                          : entry_count_q;
  assign dims_eff = (dim_count_q > DimCountW'(MaxDims)) ? DimCountW'(MaxDims)
                                                        : dim_count_q;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign wr_en      = in_acc && (action_i == ActWrite);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign lo_word    = rdata_q[CoordW-1:0];
  assign hi_word    = rdata_q[2*CoordW-1:CoordW];
  assign pt         = coord_q[dim_q];
  assign inside_box = (pt >= lo_word) && (pt < hi_word);
  assign last_dim   = ({1'b0, dim_q} + DimCountW'(1)) == dims_eff;
  assign last_ent   = ({1'b0, ent_q} + CountW'(1)) == n_eff;

  always_comb begin
    state_d      = state_q;
    ent_d        = ent_q;
    dim_d        = dim_q;
    hint_entry_d = hint_entry_q;
    hint_valid_d = hint_valid_q;
    res_found_d  = res_found_q;
    res_entry_d  = res_entry_q;
    res_hint_d   = res_hint_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          res_found_d = 1'b0;
          res_entry_d = '0;
          res_hint_d  = 1'b0;
          ent_d       = '0;
          dim_d       = '0;
          if (action_i == ActWrite) begin
            hint_valid_d = 1'b0;
            state_d      = StPush;
          end else if (dims_eff == '0) begin
            state_d = StScalar;
          end else if (hint_valid_q && ({1'b0, hint_entry_q} < n_eff)) begin
            ent_d   = hint_entry_q;
            state_d = StHint;
          end else if (n_eff == '0) begin
            state_d = StPush;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScalar: begin
        if ((n_eff == CountW'(1)) && (lo_word == '0) && (hi_word == CoordW'(1))) begin
          res_found_d = 1'b1;
        end
        state_d = StPush;
      end
      StHint: begin
        if (inside_box && last_dim) begin
          res_found_d = 1'b1;
          res_entry_d = ent_q;
          res_hint_d  = 1'b1;
          state_d     = StPush;
        end else if (inside_box) begin
          dim_d = dim_q + DimW'(1);
        end else begin
          ent_d   = '0;
          dim_d   = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        if (inside_box && last_dim) begin
          res_found_d  = 1'b1;
          res_entry_d  = ent_q;
          hint_entry_d = ent_q;
          hint_valid_d = 1'b1;
          state_d      = StPush;
        end else if (inside_box) begin
          dim_d = dim_q + DimW'(1);
        end else if (last_ent) begin
          state_d = StPush;
        end else begin
          ent_d = ent_q + EntryW'(1);
          dim_d = '0;
        end
      end
      StPush: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign rd_addr = {ent_d, dim_d};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[{entry_sel_i, dim_sel_i}] <= {range_high_i, range_low_i};
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (action_i == ActLookup)) begin
      coord_q[0] <= coord_a_i;
      coord_q[1] <= coord_b_i;
      coord_q[2] <= coord_c_i;
      coord_q[3] <= coord_d_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      entry_count_q <= '0;
      dim_count_q   <= '0;
      hint_entry_q  <= '0;
      hint_valid_q  <= 1'b0;
      ent_q         <= '0;
      dim_q         <= '0;
      res_found_q   <= 1'b0;
      res_entry_q   <= '0;
      res_hint_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      out_found_q   <= 1'b0;
      out_entry_q   <= '0;
      out_hint_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      hint_entry_q <= hint_entry_d;
      hint_valid_q <= hint_valid_d;
      ent_q        <= ent_d;
      dim_q        <= dim_d;
      res_found_q  <= res_found_d;
      res_entry_q  <= res_entry_d;
      res_hint_q   <= res_hint_d;
      if (cfg_wr && (paddr == RegEntryCount)) begin
        entry_count_q <= pwdata[CountW-1:0];
      end
      if (cfg_wr && (paddr == RegDimCount)) begin
        dim_count_q <= pwdata[DimCountW-1:0];
      end
      if ((state_q == StPush) && out_free) begin
        out_valid_q <= 1'b1;
        out_found_q <= res_found_q;
        out_entry_q <= res_entry_q;
        out_hint_q  <= res_hint_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign hit_entry_o = out_entry_q;
  assign from_hint_o = out_hint_q;

endmodule
`default_nettype wire

/* rtl/brl_checker.sv */
// Port-level checker for the box region lookup and its bind statement.
`default_nettype none
module brl_checker import brl_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic              found_o,
  input wire logic [EntryW-1:0] hit_entry_o,
  input wire logic              from_hint_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A miss or a write reports entry zero and no hint.
  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> (hit_entry_o == '0) && !from_hint_o)
    else $error("miss result carries an entry or hint flag");

  // Only a found entry can come from the hint.
  a_hint_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && from_hint_o |-> found_o)
    else $error("hint answer without found");

  // After an item is taken the block is busy in the following cycle.
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("new item taken right after another");

endmodule

bind box_region_lookup_with_hint brl_checker u_brl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .found_o     (found_o),
  .hit_entry_o (hit_entry_o),
  .from_hint_o (from_hint_o)
);
`default_nettype wire
